// ===== hw/rtl/hc2p_pkg.sv =====
// ----------------------------------------------------------------------------
// hc2p_pkg
// Types and constants shared by the 2x2 pair cipher and its channel interfaces.
// ----------------------------------------------------------------------------
package hc2p_pkg;

   localparam int DATA_W     = 10;
   localparam int VALUE_W    = 11;
   localparam int KEY_W      = 4;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   typedef logic [DATA_W-1:0]         data_type;
   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [KEY_W-1:0]          key_type;

   // Pad symbol, valid both as a raw number and as a character code.
   localparam data_type PAD_CODE       = 10'd29;
   localparam data_type CHAR_LOWER_A   = 10'd97;
   localparam data_type CHAR_LOWER_Z   = 10'd122;
   localparam data_type CHAR_UPPER_A   = 10'd65;
   localparam data_type CHAR_UPPER_Z   = 10'd90;
   localparam data_type CASE_OFFSET    = 10'd32;
   localparam data_type LETTER_OFFSET  = 10'd64;
   localparam logic [7:0] CHAR_HASH    = 8'd35;
   localparam logic [7:0] CHAR_BEFORE_A = 8'd64;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MODE    = 3'd0,
      REG_KEY_A00 = 3'd1,
      REG_KEY_A01 = 3'd2,
      REG_KEY_A10 = 3'd3,
      REG_KEY_A11 = 3'd4
   } csr_index_type;

   typedef struct packed {
      data_type p;
      data_type q;
      logic     last;
   } pair_type;

endpackage

// ===== hw/rtl/hc2p_req_if.sv =====
// ----------------------------------------------------------------------------
// hc2p_req_if
// Request channel of the pair cipher: one symbol and its end-of-message flag.
// ----------------------------------------------------------------------------
interface hc2p_req_if;
   import hc2p_pkg::*;

   logic     valid;
   logic     ready;
   data_type data;
   logic     last;

   modport source (output valid, output data, output last, input ready);
   modport sink   (input valid, input data, input last, output ready);
endinterface

// ===== hw/rtl/hc2p_rsp_if.sv =====
// ----------------------------------------------------------------------------
// hc2p_rsp_if
// Result channel of the pair cipher: one cipher number or character per beat.
// ----------------------------------------------------------------------------
interface hc2p_rsp_if;
   import hc2p_pkg::*;

   logic      valid;
   logic      ready;
   value_type value;
   logic      last_out;
   logic      key_invalid;

   modport source (output valid, output value, output last_out, output key_invalid,
                   input ready);
   modport sink   (input valid, input value, input last_out, input key_invalid,
                   output ready);
endinterface

// ===== hw/rtl/hill_cipher_2x2_pairs_top.sv =====
// ----------------------------------------------------------------------------
// hill_cipher_2x2_pairs_top
// Hill-style 2x2 cipher on symbol pairs, without modulus, with an APB key port.
// ----------------------------------------------------------------------------
// The block accepts one request per clock cycle while req_ch.ready is high.
// Requests are gathered in pairs; the first of a pair is only held, and the
// request that completes it (or a lone final request, which is padded with
// 29) produces two results. The pair enters a pair register when accepted,
// both products are formed into the result register once that is free, and
// the two results then leave in order. The result port, one result per cycle
// while rsp_ch.ready is high, sets the rate: paired traffic sustains one
// request per cycle, while a padded final request occupies the result port
// for both of its results. The pair register and the result register are
// independent, so a new pair is taken while the previous one is still being
// delivered. In encrypt mode each symbol is upper-cased and mapped to 1..26,
// any other value to 29; in decrypt mode the pair is multiplied by the
// integer inverse of the key (its adjugate times a determinant of +1 or -1)
// and each number is mapped back to a character. key_invalid flags a key
// whose determinant is neither +1 nor -1. The user must write registers over
// APB only while the block is idle; the block does not enforce this. The key
// in force when a pair enters the result register is the one used.
// ----------------------------------------------------------------------------
module hill_cipher_2x2_pairs_top (
   input  logic                                  clock,
   input  logic                                  reset,
   hc2p_req_if.sink                              req_ch,
   hc2p_rsp_if.source                            rsp_ch,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [hc2p_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [hc2p_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [hc2p_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                  pready
);
   import hc2p_pkg::*;

   // Configuration registers.
   logic    mode_ff, mode_in;
   key_type key_a00_ff, key_a00_in;
   key_type key_a01_ff, key_a01_in;
   key_type key_a10_ff, key_a10_in;
   key_type key_a11_ff, key_a11_in;

   // Pair gathering.
   logic     have_first_ff, have_first_in;
   data_type first_held_ff, first_held_in;
   logic     pair_vld_ff, pair_vld_in;
   pair_type pair_ff, pair_in;

   // Result register, delivered as two beats.
   logic      res_vld_ff, res_vld_in;
   logic      res_sel_ff, res_sel_in;
   value_type res0_ff, res0_in;
   value_type res1_ff, res1_in;
   logic      res_last_ff, res_last_in;
   logic      res_bad_ff, res_bad_in;

   logic          csr_write;
   csr_index_type csr_index;
   logic          req_accept;
   logic          rsp_accept;
   logic          res_free;
   logic          pair_adv;

   // Datapath.
   logic signed [16:0] k00, k01, k10, k11;
   logic signed [16:0] p_op, q_op;
   logic signed [16:0] det;
   logic signed [16:0] enc0, enc1;
   logic signed [16:0] dec0, dec1;
   logic               key_bad;
   logic               det_neg;
   logic [7:0]         chr0, chr1;

   function automatic logic [4:0] encode_char(input data_type d);
      data_type u;
      u = ((d >= CHAR_LOWER_A) && (d <= CHAR_LOWER_Z)) ? (d - CASE_OFFSET) : d;
      if ((u >= CHAR_UPPER_A) && (u <= CHAR_UPPER_Z)) begin
         return 5'(u - LETTER_OFFSET);
      end
      return 5'(PAD_CODE);
   endfunction

   function automatic logic [7:0] decode_num(input logic signed [16:0] n);
      if (n == 17'(PAD_CODE)) begin
         return CHAR_HASH;
      end
      return n[7:0] + CHAR_BEFORE_A;
   endfunction

   // ---------------------------------------------------------------------
   // Configuration port. A write lands at the access phase; pready is tied
   // high, so every transfer completes in its access phase.
   // ---------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = csr_index_type'(paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      mode_in    = mode_ff;
      key_a00_in = key_a00_ff;
      key_a01_in = key_a01_ff;
      key_a10_in = key_a10_ff;
      key_a11_in = key_a11_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_MODE:    mode_in    = pwdata[0];
            REG_KEY_A00: key_a00_in = pwdata[KEY_W-1:0];
            REG_KEY_A01: key_a01_in = pwdata[KEY_W-1:0];
            REG_KEY_A10: key_a10_in = pwdata[KEY_W-1:0];
            REG_KEY_A11: key_a11_in = pwdata[KEY_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (csr_index)
         REG_MODE:    prdata = CSR_DATA_W'(mode_ff);
         REG_KEY_A00: prdata = CSR_DATA_W'(key_a00_ff);
         REG_KEY_A01: prdata = CSR_DATA_W'(key_a01_ff);
         REG_KEY_A10: prdata = CSR_DATA_W'(key_a10_ff);
         REG_KEY_A11: prdata = CSR_DATA_W'(key_a11_ff);
         default:     prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Handshake and flow. The result register frees when its second beat is
   // taken; the pair register moves on whenever the result register is free,
   // and a request is taken whenever the pair register is, or is emptying.
   // ---------------------------------------------------------------------
   assign res_free     = !res_vld_ff || (res_sel_ff && rsp_ch.ready);
   assign pair_adv     = pair_vld_ff && res_free;
   assign req_ch.ready = !pair_vld_ff || pair_adv;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign rsp_accept   = rsp_ch.valid && rsp_ch.ready;

   always_comb begin
      have_first_in = have_first_ff;
      first_held_in = first_held_ff;
      pair_in       = pair_ff;
      pair_vld_in   = pair_vld_ff;
      if (pair_adv) begin
         pair_vld_in = 1'b0;
      end
      if (req_accept) begin
         if (have_first_ff) begin
            // Second request completes the pair.
            have_first_in = 1'b0;
            pair_in.p     = first_held_ff;
            pair_in.q     = req_ch.data;
            pair_in.last  = req_ch.last;
            pair_vld_in   = 1'b1;
         end else if (req_ch.last) begin
            // A lone final request is padded; 29 is the pad in both modes.
            pair_in.p    = req_ch.data;
            pair_in.q    = PAD_CODE;
            pair_in.last = 1'b1;
            pair_vld_in  = 1'b1;
         end else begin
            have_first_in = 1'b1;
            first_held_in = req_ch.data;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Pair arithmetic: two small multiply-adds per result, both modes formed
   // in parallel and selected by mode.
   // ---------------------------------------------------------------------
   always_comb begin
      k00 = 17'(key_a00_ff);
      k01 = 17'(key_a01_ff);
      k10 = 17'(key_a10_ff);
      k11 = 17'(key_a11_ff);
      det     = k00 * k11 - k01 * k10;
      key_bad = (det != 17'sd1) && (det != -17'sd1);
      det_neg = (det == -17'sd1);

      if (mode_ff) begin
         p_op = 17'(pair_ff.p);
         q_op = 17'(pair_ff.q);
      end else begin
         p_op = 17'(encode_char(pair_ff.p));
         q_op = 17'(encode_char(pair_ff.q));
      end

      enc0 = k00 * p_op + k01 * q_op;
      enc1 = k10 * p_op + k11 * q_op;

      // Adjugate product; an invalid key leaves it unscaled.
      dec0 = k11 * p_op - k01 * q_op;
      dec1 = k00 * q_op - k10 * p_op;
      if (det_neg) begin
         dec0 = -dec0;
         dec1 = -dec1;
      end
      chr0 = decode_num(dec0);
      chr1 = decode_num(dec1);
   end

   always_comb begin
      res_vld_in  = res_vld_ff;
      res_sel_in  = res_sel_ff;
      res0_in     = res0_ff;
      res1_in     = res1_ff;
      res_last_in = res_last_ff;
      res_bad_in  = res_bad_ff;
      if (rsp_accept) begin
         if (res_sel_ff) begin
            res_vld_in = 1'b0;
            res_sel_in = 1'b0;
         end else begin
            res_sel_in = 1'b1;
         end
      end
      if (pair_adv) begin
         res_vld_in  = 1'b1;
         res_sel_in  = 1'b0;
         res_last_in = pair_ff.last;
         res_bad_in  = key_bad;
         if (mode_ff) begin
            res0_in = VALUE_W'(chr0);
            res1_in = VALUE_W'(chr1);
         end else begin
            res0_in = enc0[VALUE_W-1:0];
            res1_in = enc1[VALUE_W-1:0];
         end
      end
   end

   assign rsp_ch.valid       = res_vld_ff;
   assign rsp_ch.value       = res_sel_ff ? res1_ff : res0_ff;
   assign rsp_ch.last_out    = res_sel_ff && res_last_ff;
   assign rsp_ch.key_invalid = res_bad_ff;

   // ---------------------------------------------------------------------
   // Registers.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= 1'b0;
         key_a00_ff    <= 4'd1;
         key_a01_ff    <= 4'd0;
         key_a10_ff    <= 4'd0;
         key_a11_ff    <= 4'd1;
         have_first_ff <= 1'b0;
         pair_vld_ff   <= 1'b0;
         res_vld_ff    <= 1'b0;
         res_sel_ff    <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         key_a00_ff    <= key_a00_in;
         key_a01_ff    <= key_a01_in;
         key_a10_ff    <= key_a10_in;
         key_a11_ff    <= key_a11_in;
         have_first_ff <= have_first_in;
         pair_vld_ff   <= pair_vld_in;
         res_vld_ff    <= res_vld_in;
         res_sel_ff    <= res_sel_in;
      end
   end

   always_ff @(posedge clock) begin
      first_held_ff <= first_held_in;
      pair_ff       <= pair_in;
      res0_ff       <= res0_in;
      res1_ff       <= res1_in;
      res_last_ff   <= res_last_in;
      res_bad_ff    <= res_bad_in;
   end

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
   // After the first beat of a pair is taken, the second beat follows.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && !res_sel_ff) |=> (rsp_ch.valid && res_sel_ff))
      else $error("second result of a pair was dropped");

   // The end-of-message flag only rides on the second result of a pair.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.last_out) |-> res_sel_ff)
      else $error("last_out raised on the first result of a pair");

   // A pair waiting for the result register is neither lost nor overwritten.
   assert property (@(posedge clock) disable iff (reset)
      (pair_vld_ff && !pair_adv) |=> (pair_vld_ff && $stable(pair_ff)))
      else $error("waiting pair was disturbed");

   // Completing a pair releases the held symbol.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && have_first_ff) |=> (!have_first_ff && pair_vld_ff))
      else $error("pair completion did not release the held symbol");

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 2x2 Hill-style pair cipher. Symbols go in over
// the request channel while the key and mode are set through the APB port.
// A scoreboard predicts both results of every completed or padded pair and
// checks them in order against the result channel. Both sides of the stream
// idle and stall in random bursts.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import hc2p_pkg::*;

   localparam int REG_COUNT    = 5;
   localparam int REG_STRIDE   = 4;
   localparam int LAST_ADDR_IX = (1 << CSR_ADDR_W) / REG_STRIDE - 1;
   localparam int MAX_DATA     = 522;
   localparam int RANDOM_ITEMS = 1000;
   localparam int TAIL_ITEMS   = 150;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 500000;
   localparam logic [31:0] MODE_MASK = 32'h1;
   localparam logic [31:0] KEY_MASK  = 32'hF;

   // One beat on the result channel.
   typedef struct {
      value_type value;
      logic      last_out;
      logic      key_invalid;
   } cipher_beat_type;

   // The scoreboard keeps its own copy of the registers and of the half-built
   // pair, and the queue of results that the block still owes.
   class hill_pair_scoreboard;
      logic            mode_reg;
      key_type         a00, a01, a10, a11;
      data_type        held_data;
      bit              holding;
      cipher_beat_type owed[$];
      int unsigned     error_count;

      function new();
         mode_reg    = 1'b0;
         a00         = 4'd1;
         a01         = 4'd0;
         a10         = 4'd0;
         a11         = 4'd1;
         held_data   = '0;
         holding     = 1'b0;
         error_count = 0;
      endfunction

      function void write_register(int unsigned idx, logic [31:0] wdata);
         case (idx)
            REG_MODE:    mode_reg = wdata[0];
            REG_KEY_A00: a00 = wdata[KEY_W-1:0];
            REG_KEY_A01: a01 = wdata[KEY_W-1:0];
            REG_KEY_A10: a10 = wdata[KEY_W-1:0];
            REG_KEY_A11: a11 = wdata[KEY_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] register_value(int unsigned idx);
         case (idx)
            REG_MODE:    return {31'b0, mode_reg};
            REG_KEY_A00: return {28'b0, a00};
            REG_KEY_A01: return {28'b0, a01};
            REG_KEY_A10: return {28'b0, a10};
            REG_KEY_A11: return {28'b0, a11};
            default:     return 32'b0;
         endcase
      endfunction

      function int determinant();
         return int'(a00) * int'(a11) - int'(a01) * int'(a10);
      endfunction

      // Letters of either case give 1..26, everything else the pad code.
      function int symbol_code(data_type d);
         data_type u;
         u = d;
         if (u >= CHAR_LOWER_A && u <= CHAR_LOWER_Z) u = u - CASE_OFFSET;
         if (u >= CHAR_UPPER_A && u <= CHAR_UPPER_Z) return int'(u - LETTER_OFFSET);
         return int'(PAD_CODE);
      endfunction

      function logic [7:0] char_of_number(int n);
         int t;
         if (n == int'(PAD_CODE)) return CHAR_HASH;
         t = n + int'(CHAR_BEFORE_A);
         return t[7:0];
      endfunction

      function void emit_pair(data_type p_raw, data_type q_raw, bit q_pad, logic fin);
         int              det, s, p, q, r0, r1;
         bit              bad;
         cipher_beat_type b0, b1;
         det = determinant();
         bad = !(det == 1 || det == -1);
         if (mode_reg == 1'b0) begin
            p  = symbol_code(p_raw);
            q  = q_pad ? int'(PAD_CODE) : symbol_code(q_raw);
            r0 = int'(a00) * p + int'(a01) * q;
            r1 = int'(a10) * p + int'(a11) * q;
         end else begin
            // A bad key is inverted with a scale of one, i.e. the bare adjugate.
            s  = bad ? 1 : det;
            p  = int'(p_raw);
            q  = q_pad ? int'(PAD_CODE) : int'(q_raw);
            r0 = int'(char_of_number(s * (int'(a11) * p - int'(a01) * q)));
            r1 = int'(char_of_number(s * (int'(a00) * q - int'(a10) * p)));
         end
         b0.value       = r0[VALUE_W-1:0];
         b0.last_out    = 1'b0;
         b0.key_invalid = bad;
         b1.value       = r1[VALUE_W-1:0];
         b1.last_out    = fin;
         b1.key_invalid = bad;
         owed.push_back(b0);
         owed.push_back(b1);
      endfunction

      function void accept_symbol(data_type d, logic fin);
         if (holding) begin
            holding = 1'b0;
            emit_pair(held_data, d, 1'b0, fin);
            held_data = '0;
         end else if (fin) begin
            emit_pair(d, '0, 1'b1, 1'b1);
         end else begin
            held_data = d;
            holding   = 1'b1;
         end
      endfunction

      function void check_output(value_type v, logic lo, logic ki);
         cipher_beat_type want;
         if (owed.size() == 0) begin
            $display("%0t: unexpected result: value %0d last_out %b key_invalid %b",
                     $time, v, lo, ki);
            error_count++;
            return;
         end
         want = owed.pop_front();
         if (v !== want.value) begin
            $display("%0t: value mismatch: expected %0d, actual %0d", $time, want.value, v);
            error_count++;
         end
         if (lo !== want.last_out) begin
            $display("%0t: last_out mismatch: expected %b, actual %b",
                     $time, want.last_out, lo);
            error_count++;
         end
         if (ki !== want.key_invalid) begin
            $display("%0t: key_invalid mismatch: expected %b, actual %b",
                     $time, want.key_invalid, ki);
            error_count++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   hc2p_req_if req_ch ();
   hc2p_rsp_if rsp_ch ();

   hill_cipher_2x2_pairs_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   hill_pair_scoreboard pair_cipher;

   int unsigned cycle_count  = 0;
   int unsigned symbols_sent = 0;
   int unsigned gap_percent  = 0;
   bit          tail_quiet   = 1'b0;
   int unsigned ready_burst  = 0;
   bit          ready_hold   = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The result side runs in random-length bursts, each either ready or stall.
   // In the tail of the run ready simply stays high.
   always @(posedge clock) begin
      if (tail_quiet) begin
         rsp_ch.ready <= 1'b1;
      end else begin
         if (ready_burst == 0) begin
            ready_hold  = ($urandom_range(0, 2) == 0);
            ready_burst = $urandom_range(1, 12);
         end
         ready_burst--;
         rsp_ch.ready <= !ready_hold;
      end
   end

   // Results are sampled at the edge that accepts them, before the block
   // updates its outputs for the next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         pair_cipher.check_output(rsp_ch.value, rsp_ch.last_out, rsp_ch.key_invalid);
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("hill_cipher_2x2_pairs_top test failed");
         $finish;
      end
   end

   function automatic logic [CSR_ADDR_W-1:0] reg_addr(int unsigned idx);
      logic [CSR_ADDR_W-1:0] a;
      a = CSR_ADDR_W'(idx * REG_STRIDE);
      return a;
   endfunction

   // Random bits above the field width must be ignored by the block.
   function automatic logic [31:0] with_junk(logic [31:0] v, logic [31:0] mask);
      logic [31:0] junk;
      junk = $urandom_range(0, 1) ? ($urandom() & ~mask) : 32'h0;
      return junk | (v & mask);
   endfunction

   // APB write: setup, then access until pready.
   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [31:0] wdata);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      pair_cipher.write_register(addr / REG_STRIDE, wdata);
   endtask

   // APB read of one register, checked against the scoreboard's copy.
   task automatic csr_read_check(int unsigned idx);
      logic [31:0] want;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= reg_addr(idx);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      want = pair_cipher.register_value(idx);
      if (prdata !== want) begin
         $display("%0t: register %0d readback mismatch: expected %h, actual %h",
                  $time, idx, want, prdata);
         pair_cipher.error_count++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Writes every register, now and then pokes an unused address, and reads
   // everything back.
   task automatic load_settings(logic m, int k00, int k01, int k10, int k11);
      csr_write(reg_addr(REG_MODE),    with_junk(32'(m),   MODE_MASK));
      csr_write(reg_addr(REG_KEY_A00), with_junk(32'(k00), KEY_MASK));
      csr_write(reg_addr(REG_KEY_A01), with_junk(32'(k01), KEY_MASK));
      csr_write(reg_addr(REG_KEY_A10), with_junk(32'(k10), KEY_MASK));
      csr_write(reg_addr(REG_KEY_A11), with_junk(32'(k11), KEY_MASK));
      if ($urandom_range(0, 2) == 0)
         csr_write(reg_addr($urandom_range(REG_COUNT, LAST_ADDR_IX)), $urandom());
      for (int i = 0; i < REG_COUNT; i++) csr_read_check(i);
   endtask

   // Drives one request and returns at the edge that accepts it. A random
   // gap may come first unless the run is in its quiet tail.
   task automatic send_symbol(data_type d, logic fin);
      if (!tail_quiet && gap_percent != 0 && $urandom_range(1, 100) <= gap_percent) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= d;
      req_ch.last  <= fin;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      pair_cipher.accept_symbol(d, fin);
   endtask

   // Registers may only change while the block is idle, so the request
   // channel is closed, every owed result is collected, and a further drain
   // wait follows in case a pair is still moving through the pipeline.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (pair_cipher.owed.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic data_type text_byte();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return CHAR_UPPER_A + DATA_W'($urandom_range(0, 25));
         4, 5, 6:    return CHAR_LOWER_A + DATA_W'($urandom_range(0, 25));
         7:          return DATA_W'($urandom_range(0, 255));
         8: begin
            case ($urandom_range(0, 3))
               0:       return CHAR_UPPER_A - 10'd1;
               1:       return CHAR_UPPER_Z + 10'd1;
               2:       return CHAR_LOWER_A - 10'd1;
               default: return CHAR_LOWER_Z + 10'd1;
            endcase
         end
         default:    return DATA_W'($urandom_range(256, MAX_DATA));
      endcase
   endfunction

   function automatic int plain_code();
      return ($urandom_range(0, 7) == 0) ? int'(PAD_CODE) : $urandom_range(1, 26);
   endfunction

   // One message of random content. In decrypt mode most pairs are real
   // ciphertext under the current key, so the inverse yields letters; the
   // rest are random numbers, always sent two at a time to keep alignment.
   task automatic send_message(int unsigned length, logic closed);
      data_type msg[$];
      data_type d;
      int       p, q;
      while (msg.size() < length) begin
         if (pair_cipher.mode_reg == 1'b0) begin
            msg.push_back(text_byte());
         end else if ($urandom_range(0, 4) != 0) begin
            p = plain_code();
            q = plain_code();
            d = DATA_W'(int'(pair_cipher.a00) * p + int'(pair_cipher.a01) * q);
            msg.push_back(d);
            d = DATA_W'(int'(pair_cipher.a10) * p + int'(pair_cipher.a11) * q);
            msg.push_back(d);
         end else begin
            d = DATA_W'($urandom_range(0, MAX_DATA));
            msg.push_back(d);
            d = DATA_W'($urandom_range(0, MAX_DATA));
            msg.push_back(d);
         end
      end
      while (msg.size() > length) void'(msg.pop_back());
      foreach (msg[i]) send_symbol(msg[i], closed && (i == length - 1));
      symbols_sent += length;
   endtask

   // Random key, often forced to be unimodular so decrypt is meaningful.
   task automatic random_settings();
      int k00, k01, k10, k11, det;
      bit unimodular;
      unimodular = 1'($urandom_range(0, 1));
      do begin
         k00 = $urandom_range(0, 9);
         k01 = $urandom_range(0, 9);
         k10 = $urandom_range(0, 9);
         k11 = $urandom_range(0, 9);
         det = k00 * k11 - k01 * k10;
      end while (unimodular && !(det == 1 || det == -1));
      load_settings(1'($urandom_range(0, 1)), k00, k01, k10, k11);
   endtask

   initial begin
      int unsigned phase;
      int unsigned phase_goal;
      int unsigned length;

      pair_cipher = new();
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
      req_ch.last  <= 1'b0;
      psel         <= 1'b0;
      penable      <= 1'b0;
      pwrite       <= 1'b0;
      paddr        <= '0;
      pwdata       <= '0;
      reset        <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part. First confirm the reset values of the registers, then
      // run letters, the characters just outside both letter ranges, and
      // zero and MAX_DATA through the identity key in encrypt mode.
      for (int i = 0; i < REG_COUNT; i++) csr_read_check(i);
      send_symbol(CHAR_UPPER_A, 1'b0);
      send_symbol(CHAR_UPPER_Z, 1'b0);
      send_symbol(CHAR_LOWER_A, 1'b0);
      send_symbol(CHAR_LOWER_Z, 1'b0);
      send_symbol(CHAR_UPPER_A - 10'd1, 1'b0);
      send_symbol(CHAR_UPPER_Z + 10'd1, 1'b0);
      send_symbol(CHAR_LOWER_A - 10'd1, 1'b0);
      send_symbol(CHAR_LOWER_Z + 10'd1, 1'b0);
      send_symbol('0, 1'b0);
      send_symbol(DATA_W'(MAX_DATA), 1'b1);
      // A lone final symbol gets padded with the pad code.
      send_symbol(CHAR_LOWER_A + 10'd12, 1'b1);

      // Leave a first symbol held, then switch to decrypt with a key of
      // determinant -1: the held raw value must be read as a number.
      send_symbol(CHAR_UPPER_A + 10'd16, 1'b0);
      drain_results();
      load_settings(1'b1, 8, 9, 1, 1);
      send_symbol(PAD_CODE, 1'b0);
      send_symbol('0, 1'b0);
      send_symbol(DATA_W'(MAX_DATA), 1'b0);
      send_symbol(PAD_CODE, 1'b0);
      send_symbol(PAD_CODE, 1'b1);
      // Padding applies in decrypt mode too.
      send_symbol(10'd100, 1'b1);

      // Change only one key entry while a symbol is held. The new key has a
      // determinant of -9, so the bare adjugate is used and results are flagged.
      send_symbol(10'd7, 1'b0);
      drain_results();
      csr_write(reg_addr(REG_KEY_A00), 32'h0);
      send_symbol(DATA_W'(MAX_DATA), 1'b1);

      // All-nines key in encrypt mode: largest products, singular key.
      drain_results();
      load_settings(1'b0, 9, 9, 9, 9);
      csr_write(reg_addr(REG_COUNT), 32'hFFFF_FFFF);
      for (int i = 0; i < REG_COUNT; i++) csr_read_check(i);
      send_symbol(CHAR_LOWER_Z, 1'b0);
      send_symbol(CHAR_UPPER_Z, 1'b1);

      // Largest decrypt products wrap to the low eight bits.
      drain_results();
      load_settings(1'b1, 9, 8, 1, 1);
      send_symbol(DATA_W'(MAX_DATA), 1'b0);
      send_symbol(DATA_W'(MAX_DATA), 1'b1);

      // Random part, in phases with a fresh setting each. The first few
      // phases use extreme keys; later ones draw the key at random. Some
      // messages end without the last flag, so a held symbol can straddle
      // a register change.
      phase = 0;
      while (symbols_sent < RANDOM_ITEMS) begin
         drain_results();
         case (phase)
            0:       load_settings(1'b1, 9, 9, 9, 9);
            1:       load_settings(1'b0, 0, 0, 0, 0);
            2:       load_settings(1'b1, 0, 0, 0, 0);
            3:       load_settings(1'b0, 9, 8, 1, 1);
            4:       load_settings(1'b1, 1, 1, 8, 9);
            default: random_settings();
         endcase
         case ($urandom_range(0, 2))
            0:       gap_percent = 0;
            1:       gap_percent = 15;
            default: gap_percent = 40;
         endcase
         phase_goal = symbols_sent + $urandom_range(60, 140);
         while (symbols_sent < phase_goal && symbols_sent < RANDOM_ITEMS) begin
            if (RANDOM_ITEMS - symbols_sent <= TAIL_ITEMS) tail_quiet = 1'b1;
            length = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                 : $urandom_range(1, 12);
            send_message(length, $urandom_range(0, 9) != 0);
         end
         phase++;
      end

      drain_results();
      if (pair_cipher.error_count == 0) begin
         $display("hill_cipher_2x2_pairs_top test passed");
      end else begin
         $display("hill_cipher_2x2_pairs_top test failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/hc2p_pkg.sv
hw/rtl/hc2p_req_if.sv
hw/rtl/hc2p_rsp_if.sv
hw/rtl/hill_cipher_2x2_pairs_top.sv
sim/tb.sv
